// ===== rtl/lif_pkg.sv =====
// Shared types and constants for the toroidal life grid block.
// Used by every module under rtl/; no dependencies.
`default_nettype none
package lif_pkg;

  localparam int ROW_W   = 64;   // cells per row word
  localparam int ADDR_W  = 6;    // row address bits
  localparam int DIM_W   = 7;    // active size register width
  localparam int GEN_W   = 8;    // generation count width
  localparam int GRID_ROWS = 64;

  localparam logic [DIM_W-1:0] MIN_DIM = 7'd3;
  localparam logic [DIM_W-1:0] MAX_DIM = 7'd64;

  // configuration register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_TOGGLE = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_READ   = 2'd3
  } lif_cmd_t;

  typedef struct packed {
    lif_cmd_t          command;
    logic [5:0]        column;
    logic [5:0]        row;
    logic              cell_value;
    logic [GEN_W-1:0]  generation_count;
  } lif_in_t;

  typedef struct packed {
    logic ok;
    logic read_value;
  } lif_out_t;

endpackage
`default_nettype wire

// ===== rtl/lif_grid_ram.sv =====
// Grid store: one row word per entry, registered read, per-row valid bits.
// Depends on lif_pkg.
`default_nettype none
module lif_grid_ram (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        we,
  input  wire logic [lif_pkg::ADDR_W-1:0]  waddr,
  input  wire logic [lif_pkg::ROW_W-1:0]   wdata,
  input  wire logic [lif_pkg::ADDR_W-1:0]  raddr,
  output logic      [lif_pkg::ROW_W-1:0]   rdata
);
  import lif_pkg::*;

  logic [ROW_W-1:0]     mem [GRID_ROWS];
  logic [GRID_ROWS-1:0] vld_r;
  logic [ROW_W-1:0]     rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // rows never written read as dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

// ===== rtl/lif_row_rule.sv =====
// B3/S23 update of one row word from its upper, own and lower rows.
// Columns wrap at the active width; inactive columns keep their value.
// Depends on lif_pkg.
`default_nettype none
module lif_row_rule (
  input  wire logic [lif_pkg::ROW_W-1:0] up,
  input  wire logic [lif_pkg::ROW_W-1:0] mid,
  input  wire logic [lif_pkg::ROW_W-1:0] dn,
  input  wire logic [lif_pkg::DIM_W-1:0] cols,
  output logic      [lif_pkg::ROW_W-1:0] nxt
);
  import lif_pkg::*;

  logic [ADDR_W-1:0] last_idx;
  assign last_idx = ADDR_W'(cols - 7'd1);

  for (genvar c = 0; c < ROW_W; c++) begin : g_col
    localparam int LI = (c == 0) ? 0 : c - 1;
    localparam int RI = (c == ROW_W - 1) ? 0 : c + 1;
    logic       is_last;
    logic       u_l, u_r, m_l, m_r, d_l, d_r;
    logic [3:0] n;
    logic       live;

    assign is_last = (last_idx == ADDR_W'(c));
    assign u_l = (c == 0) ? up[last_idx]  : up[LI];
    assign m_l = (c == 0) ? mid[last_idx] : mid[LI];
    assign d_l = (c == 0) ? dn[last_idx]  : dn[LI];
    assign u_r = is_last ? up[0]  : up[RI];
    assign m_r = is_last ? mid[0] : mid[RI];
    assign d_r = is_last ? dn[0]  : dn[RI];

    assign n = 4'(u_l) + 4'(up[c]) + 4'(u_r) + 4'(m_l) + 4'(m_r)
             + 4'(d_l) + 4'(dn[c]) + 4'(d_r);
    assign live = (n == 4'd3) || (mid[c] && (n == 4'd2));
    assign nxt[c] = (DIM_W'(c) < cols) ? live : mid[c];
  end

endmodule
`default_nettype wire

// ===== rtl/life_automaton_torus_grid_top.sv =====
// Top level of the toroidal life grid: sequencer, config registers, output register.
// Depends on lif_pkg, lif_grid_ram and lif_row_rule.
//
// Usage:
//  - Input channel in_valid/in_stall/in_data carries one command item.
//    Items are taken only while the sequencer is idle; in_stall is high
//    while a command is being worked on.
//  - Output channel out_valid/out_stall/out_data returns one result item
//    per command, held in an output register. A new command may be taken
//    while that result still waits.
//  - Cell write, toggle and read: read row, modify, write back (a read or an
//    out-of-range cell writes nothing); the result is loaded from S_DONE.
//  - Run: each generation walks the row store with one shared row-rule
//    unit, one row word per cycle, a pace set by the single read port of
//    the grid store. After the last generation the sequencer goes to its
//    done state; a run with N = 0 goes there straight from idle.
//  - Reset (rst_n low, synchronous): all cells dead via per-row valid bits,
//    sizes back to 64x64, channels empty.
//  - If the receiver stalls, the finished result waits and the sequencer
//    holds in its done state until the output register frees up.
//  - cfg_we/cfg_index/cfg_wdata write active sizes, saturated to 3..64.
`default_nettype none
module life_automaton_torus_grid_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire lif_pkg::lif_in_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output lif_pkg::lif_out_t                out_data,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [lif_pkg::DIM_W-1:0]   cfg_wdata
);
  import lif_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CELL, S_GEN, S_DONE} state_t;

  state_t             state_r;
  lif_cmd_t           cmd_r;
  logic [5:0]         col_r, row_r;
  logic               val_r;
  logic [GEN_W-1:0]   gen_left_r;
  logic [DIM_W-1:0]   step_r;
  logic [DIM_W-1:0]   cols_r, rows_r;
  logic [ROW_W-1:0]   up_r, mid_r, row0_r;
  logic               res_ok_r, res_val_r;
  logic               out_valid_r;
  lif_out_t           out_data_r;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ROW_W-1:0]   ram_wdata, ram_rdata;
  logic [ROW_W-1:0]   dn_row, rule_row, cell_bit, cell_row;
  logic               in_range, in_acc, last_step;
  logic [DIM_W-1:0]   cfg_sat;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < MIN_DIM) r = MIN_DIM;
    if (v > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_sat   = sat_dim(cfg_wdata);

  // cell ops
  assign in_range = (DIM_W'(col_r) < cols_r) && (DIM_W'(row_r) < rows_r);
  assign cell_bit = ROW_W'(1) << col_r;
  always_comb begin
    case (cmd_r)
      CMD_TOGGLE: cell_row = ram_rdata ^ cell_bit;
      default:    cell_row = val_r ? (ram_rdata | cell_bit) : (ram_rdata & ~cell_bit);
    endcase
  end

  // generation sweep: step 0 reads the last row, then rows 0..R-1
  assign last_step = (step_r == rows_r + 7'd2);
  assign dn_row    = last_step ? row0_r : ram_rdata;

  lif_row_rule u_rule (
    .up   (up_r),
    .mid  (mid_r),
    .dn   (dn_row),
    .cols (cols_r),
    .nxt  (rule_row)
  );

  always_comb begin
    ram_raddr = in_data.row;
    if (state_r == S_GEN) begin
      ram_raddr = (step_r == '0) ? ADDR_W'(rows_r - 7'd1) : ADDR_W'(step_r - 7'd1);
    end
    ram_we    = 1'b0;
    ram_waddr = row_r;
    ram_wdata = cell_row;
    if (state_r == S_CELL) begin
      ram_we = in_range && (cmd_r != CMD_READ);
    end else if (state_r == S_GEN) begin
      ram_we    = (step_r >= 7'd3);
      ram_waddr = ADDR_W'(step_r - 7'd3);
      ram_wdata = rule_row;
    end
  end

  lif_grid_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cols_r      <= MAX_DIM;
      rows_r      <= MAX_DIM;
      gen_left_r  <= '0;
      step_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLUMNS: cols_r <= cfg_sat;
          CFG_ROWS:    rows_r <= cfg_sat;
          default:     ;
        endcase
      end
      // done state reloads the register itself when it frees up
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_data.command;
            col_r <= in_data.column;
            row_r <= in_data.row;
            val_r <= in_data.cell_value;
            step_r <= '0;
            gen_left_r <= in_data.generation_count;
            res_ok_r   <= 1'b1;
            res_val_r  <= 1'b0;
            if (in_data.command != CMD_RUN) begin
              state_r <= S_CELL;
            end else if (in_data.generation_count == '0) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_GEN;
            end
          end
        end
        S_CELL: begin
          res_ok_r  <= in_range;
          res_val_r <= in_range && (cmd_r == CMD_READ) && ram_rdata[col_r];
          state_r   <= S_DONE;
        end
        S_GEN: begin
          if (step_r == 7'd1) begin
            up_r <= ram_rdata;
          end else if (step_r == 7'd2) begin
            mid_r  <= ram_rdata;
            row0_r <= ram_rdata;
          end else if (step_r >= 7'd3) begin
            up_r  <= mid_r;
            mid_r <= dn_row;
          end
          if (last_step) begin
            step_r <= '0;
            if (gen_left_r == 8'd1) begin
              state_r <= S_DONE;
            end
            gen_left_r <= gen_left_r - 8'd1;
          end else begin
            step_r <= step_r + 7'd1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r           <= 1'b1;
            out_data_r.ok         <= res_ok_r;
            out_data_r.read_value <= res_val_r;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_write_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !ram_we)
    else $error("grid written outside a command");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  a_gen_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN) |-> (gen_left_r != '0))
    else $error("sweeping with no generations left");

endmodule
`default_nettype wire
